FILE: hdl/lfdc_pkg.sv
// Shared types and constants for the line follow and detour controller.
// No dependencies; every other file of the block imports this package.
package lfdc_pkg;

  localparam int unsigned DistW  = 10;
  localparam int unsigned CountW = 4;
  localparam int unsigned SpeedW = 8;
  localparam int unsigned MsW    = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DistW-1:0]  NoEchoCm  = DistW'(999);
  localparam logic [CountW-1:0] CountMax  = '1;

  typedef enum logic [2:0] {
    PH_FOLLOW    = 3'd0,
    PH_TURN_OUT  = 3'd1,
    PH_PASS      = 3'd2,
    PH_TURN_BACK = 3'd3,
    PH_SEARCH    = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    DIR_FWD   = 2'd0,
    DIR_BACK  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  localparam logic [2:0] MotorStop = 3'd0;

  localparam logic [2:0] CmdFwd   = 3'd2;
  localparam logic [2:0] CmdBack  = 3'd3;
  localparam logic [2:0] CmdLeft  = 3'd4;
  localparam logic [2:0] CmdRight = 3'd5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OBSTACLE_DISTANCE  = 3'd0,
    REG_OBSTACLE_DEBOUNCE  = 3'd1,
    REG_SPEED_FORWARD      = 3'd2,
    REG_SPEED_TURN         = 3'd3,
    REG_LINE_LOST_MS       = 3'd4,
    REG_TURN_MS            = 3'd5,
    REG_PASS_MS            = 3'd6,
    REG_SEARCH_MS          = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             line_left;
    logic             line_center;
    logic             line_right;
    logic [DistW-1:0] dist_front_left;
    logic [DistW-1:0] dist_front_center;
    logic [DistW-1:0] dist_front_right;
    logic             manual_mode;
    logic [2:0]       manual_cmd;
    logic             manual_stale;
    logic             powered_off;
    logic             unlock_active;
  } poll_t;

  typedef struct packed {
    logic [2:0]        motor_dir;
    logic [SpeedW-1:0] motor_speed;
    logic              log_valid;
    logic [1:0]        log_dir;
    logic [TimeW-1:0]  log_elapsed_ms;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } cfg_write_t;

endpackage

FILE: hdl/lfdc_intf.sv
// Valid/ready channel interfaces for the poll, result and configuration ports.
// Depends on lfdc_pkg for the payload structs.
interface lfdc_poll_if;
  import lfdc_pkg::*;
  logic  valid;
  logic  ready;
  poll_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lfdc_result_if;
  import lfdc_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lfdc_cfg_if;
  import lfdc_pkg::*;
  logic       valid;
  logic       ready;
  cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/line_follow_detour_controller.sv
// Line follow and detour drive controller, top level.
// Depends on lfdc_pkg and the channel interfaces in lfdc_intf.sv.
//
// Usage: each request on poll_i carries one sensor poll; for every poll the
// block returns exactly one request on result_o with the motor direction and
// speed, plus a log record when a moving segment ended on that poll.
// cfg_i writes the eight settings registers by index; it is always ready and
// should only be used while no poll is in flight.
// A poll accepted on poll_i sits in an input register, the whole control
// step is one pass of compare and select logic, and the result lands in an
// output register that drives result_o. Throughput is one poll per cycle
// while result_o does not stall.
// When result_o stalls, the held result stays put; poll_i keeps accepting
// as long as the input register is free or moves on in the same cycle, so
// one more poll waits in the input register.
// Reset clears the drive state to follow/stopped and loads the default
// settings (20 cm, count 3, speeds 180/150, 200/450/750/2500 ms).
module line_follow_detour_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  lfdc_cfg_if.sink           cfg_i,
  lfdc_poll_if.sink          poll_i,
  lfdc_result_if.source      result_o
);
  import lfdc_pkg::*;

  // Settings registers
  logic [DistW-1:0]  obst_dist_q;
  logic [CountW-1:0] obst_deb_q;
  logic [SpeedW-1:0] spd_fwd_q, spd_turn_q;
  logic [MsW-1:0]    lost_ms_q, turn_ms_q, pass_ms_q, search_ms_q;

  // Pipeline registers
  logic    in_valid_q;
  poll_t   in_q;
  logic    out_valid_q;
  result_t out_q;
  logic    advance;

  // Drive state
  phase_e            phase_q, phase_d;
  logic              moving_q, moving_d;
  dir_e              dir_q, dir_d;
  logic [SpeedW-1:0] speed_q, speed_d;
  logic [TimeW-1:0]  seg_start_q, seg_start_d;
  logic [CountW-1:0] count_q, count_d;
  logic              lost_q, lost_d;
  logic [TimeW-1:0]  lost_since_q, lost_since_d;
  logic [TimeW-1:0]  step_start_q, step_start_d;
  logic              det_left_q, det_left_d;
  logic              mode_at_q, mode_at_d;

  // Step decisions
  logic              do_end, do_drive;
  dir_e              drv_dir;
  logic [SpeedW-1:0] drv_spd;
  logic              blocked, abort_now, any_line;
  logic [TimeW-1:0]  el, lost_el, seg_el;
  logic [CountW-1:0] count_inc;
  logic [DistW-1:0]  side_l, side_r;
  logic              start_new, log_now;
  result_t           res_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obst_dist_q <= DistW'(20);
      obst_deb_q  <= CountW'(3);
      spd_fwd_q   <= SpeedW'(180);
      spd_turn_q  <= SpeedW'(150);
      lost_ms_q   <= MsW'(200);
      turn_ms_q   <= MsW'(450);
      pass_ms_q   <= MsW'(750);
      search_ms_q <= MsW'(2500);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.data.index))
        REG_OBSTACLE_DISTANCE: obst_dist_q <= cfg_i.data.wdata[DistW-1:0];
        REG_OBSTACLE_DEBOUNCE: obst_deb_q  <= cfg_i.data.wdata[CountW-1:0];
        REG_SPEED_FORWARD:     spd_fwd_q   <= cfg_i.data.wdata[SpeedW-1:0];
        REG_SPEED_TURN:        spd_turn_q  <= cfg_i.data.wdata[SpeedW-1:0];
        REG_LINE_LOST_MS:      lost_ms_q   <= cfg_i.data.wdata[MsW-1:0];
        REG_TURN_MS:           turn_ms_q   <= cfg_i.data.wdata[MsW-1:0];
        REG_PASS_MS:           pass_ms_q   <= cfg_i.data.wdata[MsW-1:0];
        REG_SEARCH_MS:         search_ms_q <= cfg_i.data.wdata[MsW-1:0];
        default: ;
      endcase
    end
  end

  // The step runs when the input register holds a poll and the output
  // register is free or is being emptied in this cycle.
  assign advance         = in_valid_q && (!out_valid_q || result_o.ready);
  assign poll_i.ready    = !in_valid_q || advance;
  assign result_o.valid  = out_valid_q;
  assign result_o.data   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (poll_i.ready) begin
      in_valid_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i.ready && poll_i.valid) begin
      in_q <= poll_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || result_o.ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  // Sensor conditions of the poll in the input register
  always_comb begin
    blocked = ((in_q.dist_front_center != '0) && (in_q.dist_front_center < obst_dist_q))
           || ((in_q.dist_front_left != '0) && (in_q.dist_front_left < obst_dist_q))
           || ((in_q.dist_front_right != '0) && (in_q.dist_front_right < obst_dist_q));
    abort_now = (in_q.manual_mode != mode_at_q) || in_q.powered_off;
    any_line  = in_q.line_left || in_q.line_center || in_q.line_right;
    el        = in_q.now_ms - step_start_q;
    lost_el   = in_q.now_ms - lost_since_q;
    seg_el    = in_q.now_ms - seg_start_q;
    count_inc = blocked ? ((count_q == CountMax) ? count_q : count_q + 1'b1) : '0;
    side_l    = (in_q.dist_front_left != '0) ? in_q.dist_front_left : NoEchoCm;
    side_r    = (in_q.dist_front_right != '0) ? in_q.dist_front_right : NoEchoCm;
  end

  // Phase decisions: which segment request (end, drive) this poll makes
  always_comb begin
    do_end       = 1'b0;
    do_drive     = 1'b0;
    drv_dir      = DIR_FWD;
    drv_spd      = spd_fwd_q;
    phase_d      = phase_q;
    count_d      = count_q;
    lost_d       = lost_q;
    lost_since_d = lost_since_q;
    step_start_d = step_start_q;
    det_left_d   = det_left_q;
    mode_at_d    = mode_at_q;
    case (phase_q)
      PH_TURN_OUT: begin
        if (el >= TimeW'(turn_ms_q)) begin
          do_end       = 1'b1;
          do_drive     = 1'b1;
          step_start_d = in_q.now_ms;
          phase_d      = PH_PASS;
        end else if (abort_now) begin
          do_end  = 1'b1;
          count_d = '0;
          phase_d = PH_FOLLOW;
        end
      end
      PH_PASS: begin
        if (el >= TimeW'(pass_ms_q)) begin
          do_end       = 1'b1;
          do_drive     = 1'b1;
          drv_dir      = det_left_q ? DIR_RIGHT : DIR_LEFT;
          drv_spd      = spd_turn_q;
          step_start_d = in_q.now_ms;
          phase_d      = PH_TURN_BACK;
        end else if (abort_now || blocked) begin
          do_end  = 1'b1;
          count_d = '0;
          phase_d = PH_FOLLOW;
        end
      end
      PH_TURN_BACK: begin
        if (el >= TimeW'(turn_ms_q)) begin
          do_drive     = 1'b1;
          step_start_d = in_q.now_ms;
          phase_d      = PH_SEARCH;
        end else if (abort_now) begin
          do_end  = 1'b1;
          count_d = '0;
          phase_d = PH_FOLLOW;
        end
      end
      PH_SEARCH: begin
        if ((el >= TimeW'(search_ms_q)) || abort_now || any_line) begin
          do_end  = 1'b1;
          lost_d  = 1'b0;
          count_d = '0;
          phase_d = PH_FOLLOW;
        end
      end
      default: begin
        phase_d = PH_FOLLOW;
        if (in_q.unlock_active || in_q.powered_off) begin
          do_end = 1'b1;
        end else if (in_q.manual_mode) begin
          do_drive = !in_q.manual_stale && ((in_q.manual_cmd == CmdFwd)
                  || (in_q.manual_cmd == CmdBack) || (in_q.manual_cmd == CmdLeft)
                  || (in_q.manual_cmd == CmdRight));
          do_end   = !do_drive;
          case (in_q.manual_cmd)
            CmdBack:  drv_dir = DIR_BACK;
            CmdLeft:  drv_dir = DIR_LEFT;
            CmdRight: drv_dir = DIR_RIGHT;
            default:  drv_dir = DIR_FWD;
          endcase
          drv_spd = ((in_q.manual_cmd == CmdLeft) || (in_q.manual_cmd == CmdRight))
                  ? spd_turn_q : spd_fwd_q;
        end else begin
          count_d = count_inc;
          if (count_inc >= obst_deb_q) begin
            det_left_d   = side_l >= side_r;
            mode_at_d    = in_q.manual_mode;
            count_d      = '0;
            do_end       = 1'b1;
            do_drive     = 1'b1;
            drv_dir      = (side_l >= side_r) ? DIR_LEFT : DIR_RIGHT;
            drv_spd      = spd_turn_q;
            step_start_d = in_q.now_ms;
            phase_d      = PH_TURN_OUT;
          end else if (any_line) begin
            lost_d   = 1'b0;
            do_drive = 1'b1;
            if (in_q.line_center) begin
              drv_dir = DIR_FWD;
            end else if (in_q.line_left) begin
              drv_dir = DIR_LEFT;
              drv_spd = spd_turn_q;
            end else begin
              drv_dir = DIR_RIGHT;
              drv_spd = spd_turn_q;
            end
          end else if (!lost_q) begin
            lost_d       = 1'b1;
            lost_since_d = in_q.now_ms;
            do_drive     = 1'b1;
          end else if (lost_el < TimeW'(lost_ms_q)) begin
            do_drive = 1'b1;
          end else begin
            do_end = 1'b1;
          end
        end
      end
    endcase
  end

  // Segment bookkeeping: a drive in the same direction keeps the segment
  // running unless this poll forced it to end first.
  always_comb begin
    start_new   = do_drive && !(moving_q && !do_end && (drv_dir == dir_q));
    log_now     = moving_q && (start_new || do_end);
    moving_d    = start_new ? 1'b1 : (do_end ? 1'b0 : moving_q);
    dir_d       = start_new ? drv_dir : dir_q;
    speed_d     = start_new ? drv_spd : speed_q;
    seg_start_d = start_new ? in_q.now_ms : seg_start_q;

    res_d.motor_dir      = moving_d ? {1'b0, dir_d} + 3'd1 : MotorStop;
    res_d.motor_speed    = moving_d ? speed_d : '0;
    res_d.log_valid      = log_now;
    res_d.log_dir        = log_now ? dir_q : DIR_FWD;
    res_d.log_elapsed_ms = log_now ? seg_el : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_FOLLOW;
      moving_q     <= 1'b0;
      dir_q        <= DIR_FWD;
      speed_q      <= '0;
      seg_start_q  <= '0;
      count_q      <= '0;
      lost_q       <= 1'b0;
      lost_since_q <= '0;
      step_start_q <= '0;
      det_left_q   <= 1'b0;
      mode_at_q    <= 1'b0;
    end else if (advance) begin
      phase_q      <= phase_d;
      moving_q     <= moving_d;
      dir_q        <= dir_d;
      speed_q      <= speed_d;
      seg_start_q  <= seg_start_d;
      count_q      <= count_d;
      lost_q       <= lost_d;
      lost_since_q <= lost_since_d;
      step_start_q <= step_start_d;
      det_left_q   <= det_left_d;
      mode_at_q    <= mode_at_d;
    end
  end

endmodule

FILE: bench/lfdc_drive_checker.sv
// Checker for the line follow and detour controller: watches the poll, result and
// settings channels, predicts the drive output of every poll and compares it.
// Depends on lfdc_pkg and the channel interfaces in lfdc_intf.sv.
module lfdc_drive_checker
  import lfdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lfdc_cfg_if         cfg_i,
  lfdc_poll_if        poll_i,
  lfdc_result_if      result_i,
  output int unsigned failures_o,
  output int unsigned pending_o
);

  // Settings copy.
  logic [DistW-1:0]  obs_cm;
  logic [CountW-1:0] debounce;
  logic [SpeedW-1:0] spd_fwd;
  logic [SpeedW-1:0] spd_turn;
  logic [MsW-1:0]    lost_ms;
  logic [MsW-1:0]    turn_ms;
  logic [MsW-1:0]    pass_ms;
  logic [MsW-1:0]    search_ms;

  // Drive state copy.
  phase_e            phase_q;
  logic              moving_q;
  dir_e              dir_q;
  logic [SpeedW-1:0] speed_q;
  logic [TimeW-1:0]  seg_t0;
  logic [TimeW-1:0]  lost_t0;
  logic [TimeW-1:0]  step_t0;
  logic [CountW-1:0] obst_cnt;
  logic              lost_q;
  logic              turn_left_q;
  logic              mode_q;

  // Segment log produced by the current poll.
  logic              log_v;
  dir_e              log_d;
  logic [TimeW-1:0]  log_ms;

  result_t motion_q[$];
  result_t want;
  result_t got;

  task close_segment(input logic [TimeW-1:0] t);
    if (moving_q) begin
      log_v    = 1'b1;
      log_d    = dir_q;
      log_ms   = t - seg_t0;
      moving_q = 1'b0;
    end
  endtask

  // A request for the direction already in motion keeps the running segment.
  task steer(input dir_e d, input logic [SpeedW-1:0] spd, input logic [TimeW-1:0] t);
    if (!(moving_q && d == dir_q)) begin
      close_segment(t);
      dir_q    = d;
      speed_q  = spd;
      seg_t0   = t;
      moving_q = 1'b1;
    end
  endtask

  task leave_detour(input logic [TimeW-1:0] t, input logic clear_lost);
    close_segment(t);
    if (clear_lost) lost_q = 1'b0;
    obst_cnt = '0;
    phase_q  = PH_FOLLOW;
  endtask

  function automatic logic is_near(logic [DistW-1:0] d);
    return d != '0 && d < obs_cm;
  endfunction

  task predict_poll(input poll_t p, output result_t r);
    logic             blocked;
    logic             abort_now;
    logic             any_line;
    logic [TimeW-1:0] el;
    logic [DistW-1:0] fl;
    logic [DistW-1:0] fr;
    blocked   = is_near(p.dist_front_center) || is_near(p.dist_front_left) ||
                is_near(p.dist_front_right);
    abort_now = (p.manual_mode != mode_q) || p.powered_off;
    any_line  = p.line_left || p.line_center || p.line_right;
    el        = p.now_ms - step_t0;
    log_v     = 1'b0;
    log_d     = DIR_FWD;
    log_ms    = '0;
    // Step expiry wins over an abort; an abort and the obstacle or line test end the detour alike.
    case (phase_q)
      PH_TURN_OUT: begin
        if (el >= turn_ms) begin
          close_segment(p.now_ms);
          step_t0 = p.now_ms;
          phase_q = PH_PASS;
          steer(DIR_FWD, spd_fwd, p.now_ms);
        end else if (abort_now) begin
          leave_detour(p.now_ms, 1'b0);
        end
      end
      PH_PASS: begin
        if (el >= pass_ms) begin
          close_segment(p.now_ms);
          step_t0 = p.now_ms;
          phase_q = PH_TURN_BACK;
          steer(turn_left_q ? DIR_RIGHT : DIR_LEFT, spd_turn, p.now_ms);
        end else if (abort_now || blocked) begin
          leave_detour(p.now_ms, 1'b0);
        end
      end
      PH_TURN_BACK: begin
        if (el >= turn_ms) begin
          steer(DIR_FWD, spd_fwd, p.now_ms);
          step_t0 = p.now_ms;
          phase_q = PH_SEARCH;
        end else if (abort_now) begin
          leave_detour(p.now_ms, 1'b0);
        end
      end
      PH_SEARCH: begin
        if (el >= search_ms || abort_now || any_line) leave_detour(p.now_ms, 1'b1);
      end
      default: begin
        phase_q = PH_FOLLOW;
        if (p.unlock_active || p.powered_off) begin
          close_segment(p.now_ms);
        end else if (p.manual_mode) begin
          if (p.manual_stale) begin
            close_segment(p.now_ms);
          end else begin
            case (p.manual_cmd)
              CmdFwd:   steer(DIR_FWD, spd_fwd, p.now_ms);
              CmdBack:  steer(DIR_BACK, spd_fwd, p.now_ms);
              CmdLeft:  steer(DIR_LEFT, spd_turn, p.now_ms);
              CmdRight: steer(DIR_RIGHT, spd_turn, p.now_ms);
              default:  close_segment(p.now_ms);
            endcase
          end
        end else begin
          if (blocked) begin
            if (obst_cnt != CountMax) obst_cnt = obst_cnt + 1'b1;
          end else begin
            obst_cnt = '0;
          end
          if (obst_cnt >= debounce) begin
            // A missing side echo counts as far away.
            fl          = (p.dist_front_left != '0) ? p.dist_front_left : NoEchoCm;
            fr          = (p.dist_front_right != '0) ? p.dist_front_right : NoEchoCm;
            turn_left_q = fl >= fr;
            mode_q      = p.manual_mode;
            obst_cnt    = '0;
            close_segment(p.now_ms);
            step_t0     = p.now_ms;
            phase_q     = PH_TURN_OUT;
            steer(turn_left_q ? DIR_LEFT : DIR_RIGHT, spd_turn, p.now_ms);
          end else if (any_line) begin
            lost_q = 1'b0;
            if (p.line_center) steer(DIR_FWD, spd_fwd, p.now_ms);
            else if (p.line_left) steer(DIR_LEFT, spd_turn, p.now_ms);
            else steer(DIR_RIGHT, spd_turn, p.now_ms);
          end else if (!lost_q) begin
            lost_q  = 1'b1;
            lost_t0 = p.now_ms;
            steer(DIR_FWD, spd_fwd, p.now_ms);
          end else if (p.now_ms - lost_t0 < lost_ms) begin
            steer(DIR_FWD, spd_fwd, p.now_ms);
          end else begin
            close_segment(p.now_ms);
          end
        end
      end
    endcase
    r.motor_dir      = moving_q ? {1'b0, dir_q} + 3'd1 : MotorStop;
    r.motor_speed    = moving_q ? speed_q : '0;
    r.log_valid      = log_v;
    r.log_dir        = log_v ? log_d : DIR_FWD;
    r.log_elapsed_ms = log_v ? log_ms : '0;
  endtask

  task apply_setting(input cfg_write_t w);
    case (cfg_reg_e'(w.index))
      REG_OBSTACLE_DISTANCE: obs_cm    = w.wdata[DistW-1:0];
      REG_OBSTACLE_DEBOUNCE: debounce  = w.wdata[CountW-1:0];
      REG_SPEED_FORWARD:     spd_fwd   = w.wdata[SpeedW-1:0];
      REG_SPEED_TURN:        spd_turn  = w.wdata[SpeedW-1:0];
      REG_LINE_LOST_MS:      lost_ms   = w.wdata;
      REG_TURN_MS:           turn_ms   = w.wdata;
      REG_PASS_MS:           pass_ms   = w.wdata;
      REG_SEARCH_MS:         search_ms = w.wdata;
      default: ;
    endcase
  endtask

  task check_field(input string name, input logic [TimeW-1:0] want_v,
                   input logic [TimeW-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
      failures_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_cm      = 10'd20;
      debounce    = 4'd3;
      spd_fwd     = 8'd180;
      spd_turn    = 8'd150;
      lost_ms     = 16'd200;
      turn_ms     = 16'd450;
      pass_ms     = 16'd750;
      search_ms   = 16'd2500;
      phase_q     = PH_FOLLOW;
      moving_q    = 1'b0;
      dir_q       = DIR_FWD;
      speed_q     = '0;
      seg_t0      = '0;
      lost_t0     = '0;
      step_t0     = '0;
      obst_cnt    = '0;
      lost_q      = 1'b0;
      turn_left_q = 1'b0;
      mode_q      = 1'b0;
      motion_q.delete();
      failures_o  = 0;
      pending_o   = 0;
    end else begin
      // A result leaving at this edge always belongs to an earlier poll.
      if (result_i.valid && result_i.ready) begin
        if (motion_q.size() == 0) begin
          $display("%0t: result with no poll waiting, got %h", $time, result_i.data);
          failures_o++;
        end else begin
          want = motion_q.pop_front();
          check_field("motor_dir", 32'(want.motor_dir), 32'(result_i.data.motor_dir));
          check_field("motor_speed", 32'(want.motor_speed), 32'(result_i.data.motor_speed));
          check_field("log_valid", 32'(want.log_valid), 32'(result_i.data.log_valid));
          check_field("log_dir", 32'(want.log_dir), 32'(result_i.data.log_dir));
          check_field("log_elapsed_ms", want.log_elapsed_ms, result_i.data.log_elapsed_ms);
        end
      end
      if (cfg_i.valid && cfg_i.ready) apply_setting(cfg_i.data);
      if (poll_i.valid && poll_i.ready) begin
        predict_poll(poll_i.data, got);
        motion_q.push_back(got);
      end
      pending_o = motion_q.size();
    end
  end

endmodule

FILE: bench/tb.sv
// Top of the controller testbench: clock, reset, poll and settings stimulus,
// result stalls and the final verdict. Depends on lfdc_pkg, the channel
// interfaces and lfdc_drive_checker, which does all prediction and comparison.
module tb;
  import lfdc_pkg::*;

  localparam int unsigned CycleLimit = 500000;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;

  logic        poll_valid = 1'b0;
  poll_t       poll_data  = '0;
  logic        cfg_valid  = 1'b0;
  cfg_write_t  cfg_data   = '0;
  logic        rx_ready   = 1'b0;

  int unsigned failures;
  int unsigned pending;
  int unsigned cycles      = 0;
  int unsigned burst_left  = 0;
  int unsigned stall_left  = 0;
  int unsigned stall_mode  = 0;
  int unsigned phase_items = 0;

  // Stimulus-side view of the settings, used only to shape the polls.
  logic [DistW-1:0]  obs_set    = 10'd20;
  logic [CountW-1:0] deb_set    = 4'd3;
  logic [MsW-1:0]    lost_set   = 16'd200;
  logic [MsW-1:0]    turn_set   = 16'd450;
  logic [MsW-1:0]    pass_set   = 16'd750;
  logic [TimeW-1:0]  clock_ms   = '0;

  lfdc_poll_if   poll_if ();
  lfdc_result_if res_if ();
  lfdc_cfg_if    cfg_if ();

  assign poll_if.valid = poll_valid;
  assign poll_if.data  = poll_data;
  assign cfg_if.valid  = cfg_valid;
  assign cfg_if.data   = cfg_data;
  assign res_if.ready  = rx_ready;

  line_follow_detour_controller u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_if),
    .poll_i   (poll_if),
    .result_o (res_if)
  );

  lfdc_drive_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_i      (cfg_if),
    .poll_i     (poll_if),
    .result_i   (res_if),
    .failures_o (failures),
    .pending_o  (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The result side switches between free flow, random stalls, heavy stalls
  // and a fixed stall period.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      0:       rx_ready <= 1'b1;
      1:       rx_ready <= 1'($urandom_range(0, 1));
      2:       rx_ready <= ($urandom_range(0, 3) == 0);
      default: rx_ready <= (cycles % 5 == 0);
    endcase
  end

  task send_poll(input poll_t p);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 40);
      repeat (gap) begin
        @(negedge clk);
        poll_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    poll_valid <= 1'b1;
    poll_data  <= p;
    do @(posedge clk); while (!poll_if.ready);
  endtask

  // Stamps the poll with the running millisecond clock and sends it.
  task emit(input poll_t p);
    p.now_ms = clock_ms;
    send_poll(p);
    phase_items++;
  endtask

  task wait_idle();
    @(negedge clk);
    poll_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= '{index: idx, wdata: value};
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task program_settings(input logic [DistW-1:0] dist_cm, input logic [CountW-1:0] deb,
                        input logic [SpeedW-1:0] sf, input logic [SpeedW-1:0] st,
                        input logic [MsW-1:0] lost, input logic [MsW-1:0] turn,
                        input logic [MsW-1:0] pass, input logic [MsW-1:0] search);
    wait_idle();
    write_reg(REG_OBSTACLE_DISTANCE, CfgDataW'(dist_cm));
    write_reg(REG_OBSTACLE_DEBOUNCE, CfgDataW'(deb));
    write_reg(REG_SPEED_FORWARD, CfgDataW'(sf));
    write_reg(REG_SPEED_TURN, CfgDataW'(st));
    write_reg(REG_LINE_LOST_MS, lost);
    write_reg(REG_TURN_MS, turn);
    write_reg(REG_PASS_MS, pass);
    write_reg(REG_SEARCH_MS, search);
    @(negedge clk);
    cfg_valid <= 1'b0;
    obs_set  = dist_cm;
    deb_set  = deb;
    lost_set = lost;
    turn_set = turn;
    pass_set = pass;
  endtask

  function automatic logic [DistW-1:0] clear_echo();
    if ($urandom_range(0, 2) == 0) return '0;
    return DistW'($urandom_range(obs_set, 1023));
  endfunction

  function automatic logic [DistW-1:0] near_echo_val();
    return (obs_set > 1) ? DistW'($urandom_range(1, obs_set - 1)) : '0;
  endfunction

  task run_episodes(input int unsigned n_items);
    int unsigned kind;
    int unsigned len;
    int unsigned step_hi;
    poll_t       p;
    phase_items = 0;
    step_hi = turn_set;
    if (pass_set > step_hi) step_hi = pass_set;
    if (lost_set > step_hi) step_hi = lost_set;
    step_hi = step_hi / 4 + 8;
    while (phase_items < n_items) begin
      kind = $urandom_range(0, 9);
      case (kind)
        0, 1, 2, 3: begin
          // Obstacle long enough to start a detour, then a walk through its steps.
          len = deb_set + $urandom_range(0, 2);
          for (int k = 0; k < len; k++) begin
            p = '0;
            p.dist_front_center = near_echo_val();
            p.dist_front_left   = DistW'($urandom_range(0, 1023));
            p.dist_front_right  = DistW'($urandom_range(0, 1023));
            clock_ms += $urandom_range(0, 30);
            emit(p);
          end
          len = $urandom_range(6, 30);
          for (int k = 0; k < len; k++) begin
            p = '0;
            p.dist_front_left   = clear_echo();
            p.dist_front_center = clear_echo();
            p.dist_front_right  = clear_echo();
            if ($urandom_range(0, 24) == 0) p.dist_front_center = near_echo_val();
            p.manual_mode   = ($urandom_range(0, 29) == 0);
            p.powered_off   = ($urandom_range(0, 39) == 0);
            p.unlock_active = ($urandom_range(0, 4) == 0);
            if (k + 3 >= len) begin
              p.line_left   = 1'($urandom_range(0, 1));
              p.line_center = 1'($urandom_range(0, 1));
              p.line_right  = 1'($urandom_range(0, 1));
            end
            clock_ms += $urandom_range(1, step_hi);
            emit(p);
          end
        end
        4, 5: begin
          len = $urandom_range(10, 30);
          for (int k = 0; k < len; k++) begin
            p = '0;
            {p.line_left, p.line_center, p.line_right} = 3'($urandom_range(0, 7));
            p.dist_front_left   = clear_echo();
            p.dist_front_center = clear_echo();
            p.dist_front_right  = clear_echo();
            if ($urandom_range(0, 9) == 0) p.dist_front_right = near_echo_val();
            p.unlock_active = ($urandom_range(0, 14) == 0);
            clock_ms += $urandom_range(0, step_hi);
            emit(p);
          end
        end
        6, 7: begin
          len = $urandom_range(5, 20);
          for (int k = 0; k < len; k++) begin
            p = '0;
            p.manual_mode  = ($urandom_range(0, 9) != 0);
            p.manual_cmd   = 3'($urandom_range(0, 7));
            p.manual_stale = ($urandom_range(0, 5) == 0);
            {p.line_left, p.line_center, p.line_right} = 3'($urandom_range(0, 7));
            p.dist_front_left   = DistW'($urandom_range(0, 1023));
            p.dist_front_center = DistW'($urandom_range(0, 1023));
            clock_ms += $urandom_range(0, 100);
            emit(p);
          end
        end
        8: begin
          len = $urandom_range(3, 10);
          for (int k = 0; k < len; k++) begin
            p.line_left         = 1'($urandom_range(0, 1));
            p.line_center       = 1'($urandom_range(0, 1));
            p.line_right        = 1'($urandom_range(0, 1));
            p.dist_front_left   = DistW'($urandom_range(0, 1023));
            p.dist_front_center = DistW'($urandom_range(0, 1023));
            p.dist_front_right  = DistW'($urandom_range(0, 1023));
            p.manual_mode       = 1'($urandom_range(0, 1));
            p.manual_cmd        = 3'($urandom_range(0, 7));
            p.manual_stale      = 1'($urandom_range(0, 1));
            p.powered_off       = 1'($urandom_range(0, 1));
            p.unlock_active     = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 2) == 0) clock_ms = $urandom;
            else clock_ms += $urandom_range(0, step_hi);
            emit(p);
          end
        end
        default: begin
          len = $urandom_range(5, 15);
          for (int k = 0; k < len; k++) begin
            p = '0;
            p.dist_front_left  = clear_echo();
            p.dist_front_right = clear_echo();
            clock_ms += $urandom_range(0, step_hi);
            emit(p);
          end
        end
      endcase
    end
  endtask

  initial begin
    poll_t p;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset settings. A halt wins over a manual command.
    clock_ms = '0;
    p = '0;
    p.unlock_active = 1'b1;
    p.manual_mode   = 1'b1;
    p.manual_cmd    = CmdFwd;
    emit(p);
    // Every manual command code, the unknown ones included.
    for (int c = 0; c < 8; c++) begin
      p = '0;
      p.manual_mode = 1'b1;
      p.manual_cmd  = 3'(c);
      clock_ms += 10;
      emit(p);
    end
    p = '0;
    p.manual_mode = 1'b1;
    p.manual_cmd  = CmdFwd;
    clock_ms += 10;
    emit(p);
    p.manual_stale = 1'b1;
    clock_ms += 5;
    emit(p);
    // Line following, then the line lost long enough to stop as arrived.
    p = '0;
    p.line_center = 1'b1;
    clock_ms += 10;
    emit(p);
    p = '0;
    p.line_left = 1'b1;
    clock_ms += 10;
    emit(p);
    p = '0;
    p.line_right = 1'b1;
    clock_ms += 10;
    emit(p);
    p = '0;
    {p.line_left, p.line_center, p.line_right} = 3'b111;
    clock_ms += 10;
    emit(p);
    p = '0;
    repeat (3) begin
      emit(p);
      clock_ms += 100;
    end
    p.powered_off = 1'b1;
    emit(p);
    // A full detour across the timestamp wrap, step lengths hit exactly.
    clock_ms = 32'hFFFF_FFF0;
    p = '0;
    p.dist_front_center = 10'd19;
    p.dist_front_right  = 10'd1023;
    repeat (3) begin
      clock_ms += 5;
      emit(p);
    end
    p = '0;
    p.dist_front_left  = 10'd20;
    p.dist_front_right = 10'd1;
    clock_ms += 449;
    emit(p);
    clock_ms += 1;
    emit(p);
    p.dist_front_right = '0;
    clock_ms += 750;
    emit(p);
    clock_ms += 450;
    emit(p);
    p.line_center = 1'b1;
    clock_ms += 10;
    emit(p);

    // Random part, one settings phase after another.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: program_settings(10'd1023, 4'd1, 8'd255, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        1: begin
          program_settings(10'd1, 4'd15, 8'd0, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          clock_ms = 32'hFFFF_0000;
        end
        2: program_settings(DistW'($urandom_range(15, 300)), 4'd0, 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 16'($urandom_range(40, 400)),
                            16'($urandom_range(40, 400)), 16'($urandom_range(40, 600)),
                            16'($urandom_range(100, 1500)));
        3: program_settings(10'd20, 4'd3, 8'd180, 8'd150, 16'd200, 16'd450, 16'd750, 16'd2500);
        default: program_settings(DistW'($urandom_range(15, 300)), 4'($urandom_range(1, 6)),
                                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  16'($urandom_range(40, 400)), 16'($urandom_range(40, 400)),
                                  16'($urandom_range(40, 600)), 16'($urandom_range(100, 1500)));
      endcase
      if (ph == 3) begin
        run_episodes(50);
        // Hold the poll side until every result of the phase so far is back.
        wait_idle();
        run_episodes(50);
      end else begin
        run_episodes(100);
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
